>>> hw/rtl/psg_pkg.sv
// psg_pkg: shared types, command codes and arithmetic helpers for the
// tone/noise sound generator. No dependencies.
package psg_pkg;

    // Fixed widths of the generator's datapath
    localparam int PERIOD_W   = 10;
    localparam int ATTEN_W    = 4;
    localparam int AMP_W      = 5;
    localparam int SCALE_W    = 17;
    localparam int SCALE_FRAC = 16;
    localparam int SCALED_W   = PERIOD_W + SCALE_W - SCALE_FRAC;
    localparam int SHIFT_W    = 16;
    localparam int SAMPLE_W   = 7;
    localparam int DATA_W     = 6;

    localparam logic [SCALE_W-1:0] RATE_SCALE_RESET = 17'd12917;
    localparam logic [SHIFT_W-1:0] SHIFT_SEED       = 16'h8000;
    localparam logic [ATTEN_W-1:0] ATTEN_SILENT     = 4'd15;
    localparam logic [1:0]         NOISE_CHAN       = 2'd3;
    localparam logic [1:0]         RATE_FROM_TONE   = 2'd3;

    // Resolved command kinds, decided in the front end
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_TICK,
        CMD_TONE_VOL,
        CMD_TONE_LO,
        CMD_TONE_HI,
        CMD_NOISE_VOL,
        CMD_NOISE_CTRL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [1:0]        chan;
        logic [DATA_W-1:0] data;
    } cmd_t;

    // Fixed noise periods for rate selects zero to two
    function automatic logic [PERIOD_W-1:0] noise_rate(input logic [1:0] sel);
        logic [PERIOD_W-1:0] r;
        case (sel)
            2'd0:    r = 10'd218;
            2'd1:    r = 10'd109;
            2'd2:    r = 10'd54;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Period times Q1.16 factor, truncated
    function automatic logic [SCALED_W-1:0] scale_period(
        input logic [PERIOD_W-1:0] p,
        input logic [SCALE_W-1:0]  s
    );
        logic [PERIOD_W+SCALE_W-1:0] prod;
        prod = (PERIOD_W+SCALE_W)'(p) * (PERIOD_W+SCALE_W)'(s);
        return prod[PERIOD_W+SCALE_W-1:SCALE_FRAC];
    endfunction

    // Flip amplitude sign at the level set by attenuation
    function automatic logic signed [AMP_W-1:0] flip_amp(
        input logic signed [AMP_W-1:0] amp,
        input logic [ATTEN_W-1:0]      atten
    );
        logic signed [AMP_W-1:0] level;
        level = $signed(AMP_W'(ATTEN_SILENT - atten));
        return (amp > 0) ? -level : level;
    endfunction

endpackage

>>> hw/rtl/psg_front.sv
// psg_front: accepts stream items, tracks the latched channel and register
// type, and resolves each item into a command. Depends on psg_pkg.
module psg_front #(
    parameter int NUM_TONES = 3
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,   // [7:0] write_data
    input  logic            s_axis_tuser,   // [0] req_type
    output logic            push_valid,
    input  logic            push_ready,
    output psg_pkg::cmd_t   push_cmd
);

    logic [1:0] latched_chan_reg, latched_chan_next;
    logic       latched_vol_reg, latched_vol_next;
    logic       is_latch;
    logic       accept;

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && push_ready;
    assign is_latch      = s_axis_tdata[7];

    // Classify the byte against the current latch
    always_comb begin
        latched_chan_next = latched_chan_reg;
        latched_vol_next  = latched_vol_reg;
        push_cmd.data     = s_axis_tdata[5:0];
        if (is_latch) begin
            latched_chan_next = s_axis_tdata[6:5];
            latched_vol_next  = s_axis_tdata[4];
            push_cmd.data     = {2'b00, s_axis_tdata[3:0]};
        end
        push_cmd.chan = latched_chan_next;
        if (s_axis_tuser) begin
            push_cmd.kind = psg_pkg::CMD_TICK;
        end else if (latched_chan_next == psg_pkg::NOISE_CHAN) begin
            push_cmd.kind = latched_vol_next ? psg_pkg::CMD_NOISE_VOL
                                             : psg_pkg::CMD_NOISE_CTRL;
        end else if (int'(latched_chan_next) >= NUM_TONES) begin
            push_cmd.kind = psg_pkg::CMD_NOP;
        end else if (latched_vol_next) begin
            push_cmd.kind = psg_pkg::CMD_TONE_VOL;
        end else if (is_latch) begin
            push_cmd.kind = psg_pkg::CMD_TONE_LO;
        end else begin
            push_cmd.kind = psg_pkg::CMD_TONE_HI;
        end
    end

    // Update the latch on accepted writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_chan_reg <= '0;
            latched_vol_reg  <= 1'b0;
        end else if (accept && !s_axis_tuser) begin
            latched_chan_reg <= latched_chan_next;
            latched_vol_reg  <= latched_vol_next;
        end
    end

endmodule

>>> hw/rtl/psg_cmd_fifo.sv
// psg_cmd_fifo: two-entry command queue between front and back end.
// Depends on psg_pkg.
module psg_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  psg_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output psg_pkg::cmd_t pop_cmd
);

    psg_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("command queue count out of range");

    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("command queue count wrong after pop");

    a_push_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("command queue count wrong after push");

endmodule

>>> hw/rtl/psg_back.sv
// psg_back: executes commands on tone and noise state, one per cycle unless a tick
// waits for a stalled output, and holds the sample output register. Depends on psg_pkg.
module psg_back #(
    parameter int NUM_TONES        = 3,
    parameter int NOISE_COUNT_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [psg_pkg::SCALE_W-1:0]      rate_scale,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  psg_pkg::cmd_t                    pop_cmd,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata   // [6:0] sample
);

    localparam int PW = psg_pkg::PERIOD_W;
    localparam int AW = psg_pkg::AMP_W;
    localparam int TW = psg_pkg::ATTEN_W;
    localparam int SW = psg_pkg::SAMPLE_W;

    logic [PW-1:0]        tone_period_reg [NUM_TONES];
    logic [TW-1:0]        tone_atten_reg  [NUM_TONES];
    logic [PW-1:0]        tone_cnt_reg    [NUM_TONES];
    logic signed [AW-1:0] tone_amp_reg    [NUM_TONES];
    logic [PW-1:0]        tone_cnt_next   [NUM_TONES];
    logic signed [AW-1:0] tone_amp_next   [NUM_TONES];

    logic [TW-1:0]                 noise_atten_reg;
    logic [1:0]                    noise_sel_reg;
    logic                          noise_white_reg;
    logic [NOISE_COUNT_BITS-1:0]   noise_cnt_reg, noise_cnt_next;
    logic signed [AW-1:0]          noise_amp_reg, noise_amp_next;
    logic [psg_pkg::SHIFT_W-1:0]   noise_shift_reg, noise_shift_next;

    logic [PW-1:0]                 noise_period;
    logic [psg_pkg::SCALED_W-1:0]  noise_scaled;
    logic                          noise_fb;
    logic signed [SW-1:0]          sum;

    logic          m_valid_reg;
    logic [7:0]    m_data_reg;
    logic          out_free;
    logic          do_pop;
    logic          is_tick;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign is_tick   = (pop_cmd.kind == psg_pkg::CMD_TICK);
    assign pop_ready = !is_tick || out_free;
    assign do_pop    = pop_valid && pop_ready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Tone tick: reload with half the scaled period and flip, or count down
    for (genvar i = 0; i < NUM_TONES; i++) begin : g_tone
        logic [psg_pkg::SCALED_W-1:0] scaled;
        assign scaled = psg_pkg::scale_period(tone_period_reg[i], rate_scale);
        always_comb begin
            if (tone_cnt_reg[i] == '0) begin
                tone_cnt_next[i] = scaled[psg_pkg::SCALED_W-1:1];
                tone_amp_next[i] = psg_pkg::flip_amp(tone_amp_reg[i], tone_atten_reg[i]);
            end else begin
                tone_cnt_next[i] = tone_cnt_reg[i] - PW'(1);
                tone_amp_next[i] = tone_amp_reg[i];
            end
        end
    end

    // Noise tick: reload, shift and flip on a one at bit 0
    assign noise_period = (noise_sel_reg == psg_pkg::RATE_FROM_TONE)
                        ? tone_period_reg[NUM_TONES-1]
                        : psg_pkg::noise_rate(noise_sel_reg);
    assign noise_scaled = psg_pkg::scale_period(noise_period, rate_scale);
    assign noise_fb     = noise_white_reg ? (noise_shift_reg[0] ^ noise_shift_reg[3])
                                          : noise_shift_reg[0];

    always_comb begin
        noise_shift_next = noise_shift_reg;
        noise_amp_next   = noise_amp_reg;
        if (noise_cnt_reg == '0) begin
            noise_shift_next = {noise_fb, noise_shift_reg[psg_pkg::SHIFT_W-1:1]};
            noise_cnt_next   = NOISE_COUNT_BITS'(noise_scaled) - NOISE_COUNT_BITS'(1);
            if (noise_shift_next[0]) begin
                noise_amp_next = psg_pkg::flip_amp(noise_amp_reg, noise_atten_reg);
            end
        end else begin
            noise_cnt_next = noise_cnt_reg - NOISE_COUNT_BITS'(1);
        end
    end

    // Mix the updated amplitudes
    always_comb begin
        sum = SW'(noise_amp_next);
        for (int i = 0; i < NUM_TONES; i++) begin
            sum = sum + SW'(tone_amp_next[i]);
        end
    end

    // Execute one command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TONES; i++) begin
                tone_period_reg[i] <= '0;
                tone_atten_reg[i]  <= psg_pkg::ATTEN_SILENT;
                tone_cnt_reg[i]    <= '0;
                tone_amp_reg[i]    <= '0;
            end
            noise_atten_reg <= psg_pkg::ATTEN_SILENT;
            noise_sel_reg   <= '0;
            noise_white_reg <= 1'b0;
            noise_cnt_reg   <= '0;
            noise_amp_reg   <= '0;
            noise_shift_reg <= '0;
        end else if (do_pop) begin
            case (pop_cmd.kind)
                psg_pkg::CMD_TICK: begin
                    for (int i = 0; i < NUM_TONES; i++) begin
                        tone_cnt_reg[i] <= tone_cnt_next[i];
                        tone_amp_reg[i] <= tone_amp_next[i];
                    end
                    noise_cnt_reg   <= noise_cnt_next;
                    noise_amp_reg   <= noise_amp_next;
                    noise_shift_reg <= noise_shift_next;
                end
                psg_pkg::CMD_TONE_VOL: begin
                    for (int i = 0; i < NUM_TONES; i++) begin
                        if (pop_cmd.chan == 2'(i)) begin
                            tone_atten_reg[i] <= pop_cmd.data[TW-1:0];
                        end
                    end
                end
                psg_pkg::CMD_TONE_LO: begin
                    for (int i = 0; i < NUM_TONES; i++) begin
                        if (pop_cmd.chan == 2'(i)) begin
                            tone_period_reg[i][3:0] <= pop_cmd.data[3:0];
                        end
                    end
                end
                psg_pkg::CMD_TONE_HI: begin
                    for (int i = 0; i < NUM_TONES; i++) begin
                        if (pop_cmd.chan == 2'(i)) begin
                            tone_period_reg[i][PW-1:4] <= pop_cmd.data;
                        end
                    end
                end
                psg_pkg::CMD_NOISE_VOL: begin
                    noise_atten_reg <= pop_cmd.data[TW-1:0];
                end
                psg_pkg::CMD_NOISE_CTRL: begin
                    noise_cnt_reg   <= '0;
                    noise_white_reg <= pop_cmd.data[2];
                    noise_sel_reg   <= pop_cmd.data[1:0];
                    noise_shift_reg <= psg_pkg::SHIFT_SEED;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the output item until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_pop && is_tick) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop && is_tick) begin
            m_data_reg <= {1'b0, sum};
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |-> !(do_pop && is_tick))
        else $error("pending sample overwritten");

    a_tick_gives_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && is_tick) |=> m_valid_reg)
        else $error("tick produced no output item");

    a_noise_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && pop_cmd.kind == psg_pkg::CMD_NOISE_CTRL)
        |=> (noise_shift_reg == psg_pkg::SHIFT_SEED && noise_cnt_reg == '0))
        else $error("noise control did not reseed");

    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($signed(m_data_reg[SW-1:0]) >= -60
                      && $signed(m_data_reg[SW-1:0]) <= 60))
        else $error("sample out of range");

endmodule

>>> hw/rtl/psg_tone_noise_generator_top.sv
// psg_tone_noise_generator_top: three tone channels and one noise channel,
// front end, command queue and back end. Depends on psg_pkg and submodules.
//
//  channel  | dir | tdata                | tuser
//  ---------+-----+----------------------+---------------
//  s_axis   | in  | [7:0] write_data     | [0] req_type
//  m_axis   | out | [6:0] sample, pad 0  | -
//  cfg_wr   | in  | [16:0] rate_scale    | -
//
// One item per cycle sustained while m_axis is not stalled; a tick's sample is
// first queued in the command queue, then registered in the back end's output
// register, and is valid on m_axis from there.
// Port writes produce no output item. Reset silences all channels, clears
// their other state and sets rate_scale to 12917. A stalled m_axis holds one
// sample; the two-entry queue then fills and s_axis_tready drops.
module psg_tone_noise_generator_top #(
    parameter int NUM_TONES        = 3,
    parameter int NOISE_COUNT_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] write_data
    input  logic                         s_axis_tuser,   // [0] req_type
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // [6:0] sample, [7] zero
    input  logic                         cfg_wr_en,
    input  logic [psg_pkg::SCALE_W-1:0]  cfg_wr_data
);

    logic [psg_pkg::SCALE_W-1:0] rate_scale_reg;
    logic                        push_valid, push_ready;
    logic                        pop_valid, pop_ready;
    psg_pkg::cmd_t               push_cmd, pop_cmd;

    // Hold the rate scale factor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_scale_reg <= psg_pkg::RATE_SCALE_RESET;
        end else if (cfg_wr_en) begin
            rate_scale_reg <= cfg_wr_data;
        end
    end

    psg_front #(
        .NUM_TONES (NUM_TONES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    psg_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    psg_back #(
        .NUM_TONES        (NUM_TONES),
        .NOISE_COUNT_BITS (NOISE_COUNT_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rate_scale    (rate_scale_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_cmd       (pop_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
